FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL folder.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/epm_pkg.sv
// ---------------------------------------------------------------------------
// epm_pkg
// Shared widths, codes and constants of the encoder position monitor.
// ---------------------------------------------------------------------------
package epm_pkg;

    localparam int unsigned DATA_W     = 32;
    localparam int unsigned RAW_W      = 16;
    localparam int unsigned DIR_W      = 2;
    // bits retired per cycle by the serial multiplier and divider
    localparam int unsigned DIGIT_BITS = 2;

    localparam logic [RAW_W-1:0] HALF_SPAN = 16'h7FFF;

    localparam logic [DIR_W-1:0] DIR_NONE = 2'b00;
    localparam logic [DIR_W-1:0] DIR_FWD  = 2'b01;
    localparam logic [DIR_W-1:0] DIR_REV  = 2'b11;

    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_INDEX  = 2'd1,
        MODE_STEP   = 2'd2,
        MODE_NOP    = 2'd3
    } t_mode;

    typedef enum logic {
        REG_ENC_SCALE  = 1'b0,
        REG_STEP_SCALE = 1'b1
    } t_reg_idx;

endpackage

FILE: hw/rtl/epm_mul.sv
// ---------------------------------------------------------------------------
// epm_mul
// Digit-serial unsigned multiplier, multiplier bits retired LSB first.
// ---------------------------------------------------------------------------
module epm_mul #(
    parameter int unsigned DIGIT_BITS = epm_pkg::DIGIT_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [epm_pkg::DATA_W-1:0]    i_mcand,
    input  logic [epm_pkg::DATA_W-1:0]    i_mplier,
    output logic                          o_done,
    output logic [2*epm_pkg::DATA_W-1:0]  o_product
);

    localparam int unsigned W     = epm_pkg::DATA_W;
    localparam int unsigned STEPS = W / DIGIT_BITS;
    localparam int unsigned CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

    logic [W-1:0]     r_hi, n_hi;
    logic [W-1:0]     r_lo, n_lo;
    logic [W-1:0]     r_mcand;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [W:0]       sum;

    // {hi, lo} shifts right; partial sums enter hi, multiplier bits leave lo
    always_comb begin
        n_hi = r_hi;
        n_lo = r_lo;
        sum  = '0;
        for (int k = 0; k < DIGIT_BITS; k++) begin
            sum  = {1'b0, n_hi} + (n_lo[0] ? {1'b0, r_mcand} : '0);
            n_hi = sum[W:1];
            n_lo = {sum[0], n_lo[W-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_hi    <= '0;
            r_lo    <= i_mplier;
            r_mcand <= i_mcand;
        end else if (r_busy) begin
            r_hi <= n_hi;
            r_lo <= n_lo;
        end
    end

    assign o_done    = r_done;
    assign o_product = {r_hi, r_lo};

endmodule

FILE: hw/rtl/epm_div.sv
// ---------------------------------------------------------------------------
// epm_div
// Digit-serial restoring divider, double-width dividend by single divisor.
// ---------------------------------------------------------------------------
module epm_div #(
    parameter int unsigned DIGIT_BITS = epm_pkg::DIGIT_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [2*epm_pkg::DATA_W-1:0]  i_dividend,
    input  logic [epm_pkg::DATA_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [2*epm_pkg::DATA_W-1:0]  o_quot
);

    localparam int unsigned W     = epm_pkg::DATA_W;
    localparam int unsigned STEPS = (2 * W) / DIGIT_BITS;
    localparam int unsigned CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

    logic [W-1:0]     r_rem, n_rem;
    logic [2*W-1:0]   r_dvd, n_dvd;
    logic [W-1:0]     r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [W:0]       trial;
    logic [W:0]       diff;
    logic             ge;

    // dividend bits leave the top of dvd, quotient bits enter at the bottom
    always_comb begin
        n_rem = r_rem;
        n_dvd = r_dvd;
        trial = '0;
        diff  = '0;
        ge    = 1'b0;
        for (int k = 0; k < DIGIT_BITS; k++) begin
            trial = {n_rem, n_dvd[2*W-1]};
            diff  = trial - {1'b0, r_div};
            ge    = (trial >= {1'b0, r_div});
            n_rem = ge ? diff[W-1:0] : trial[W-1:0];
            n_dvd = {n_dvd[2*W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= n_dvd;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dvd;

endmodule

FILE: hw/rtl/encoder_position_step_loss_monitor.sv
// ---------------------------------------------------------------------------
// encoder_position_step_loss_monitor
// Extends a 16-bit quadrature counter to a 32-bit position and checks it
// against commanded steps scaled by encoder_scale / step_scale.
// ---------------------------------------------------------------------------
// Each item updates position, index and step state in the cycle it is
// taken and returns one result item with the full state, the expected
// count and the position error. With both scale registers nonzero the
// expected count comes from a serial multiplier followed by a serial
// 64-by-32 divider, so an item passes through the multiply, divide and
// load states; with a scale register at zero it goes straight to load.
// A new item is taken once the previous result sits in the output
// register, even while that result waits for the downstream side.
`include "assert_macros.svh"

module encoder_position_step_loss_monitor #(
    parameter int unsigned DIGIT_BITS = epm_pkg::DIGIT_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input items
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [23:0]  i_s_tdata,   // [15:0] raw_count, [16] step_positive, zero pad
    input  logic [1:0]   i_s_tuser,   // [1:0] mode
    // result items
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [31:0] position, [63:32] step_total, [95:64] index_position,
    // [127:96] index_count, [143:128] last_raw, [145:144] direction,
    // [177:146] expected_count, [209:178] position_error, zero pad
    output logic [215:0] o_m_tdata,
    output logic         o_m_tuser,   // [0] scale_set
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int unsigned W        = epm_pkg::DATA_W;
    localparam int unsigned RW       = epm_pkg::RAW_W;
    localparam int unsigned DW       = epm_pkg::DIR_W;
    localparam int unsigned OUT_BITS = 6 * W + RW + DW;
    localparam int unsigned OUT_PAD  = 216 - OUT_BITS;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_LOAD = 4'b1000
    } t_state;

    t_state         r_state, n_state;

    logic [W-1:0]   r_enc_scale;
    logic [W-1:0]   r_step_scale;
    logic [W-1:0]   r_pos, n_pos;
    logic [RW-1:0]  r_prev_raw, n_prev_raw;
    logic [DW-1:0]  r_dir, n_dir;
    logic [W-1:0]   r_steps, n_steps;
    logic [W-1:0]   r_idx_pos, n_idx_pos;
    logic [W-1:0]   r_idx_cnt, n_idx_cnt;
    logic           r_neg;
    logic           r_m_valid;
    logic [215:0]   r_m_data;
    logic           r_m_user;

    logic           s_accept;
    logic           cfg_wr;
    logic           scaled;
    logic [RW-1:0]  raw;
    logic [RW-1:0]  fwd;
    logic [W-1:0]   mag;
    logic           mul_done;
    logic [2*W-1:0] product;
    logic           div_start;
    logic           div_done;
    logic [2*W-1:0] quot;
    logic           sat;
    logic [W-1:0]   qmag;
    logic [W-1:0]   expect_cnt;
    logic [W-1:0]   pos_err;
    logic           out_free;
    logic           load;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enc_scale  <= '0;
            r_step_scale <= '0;
        end else if (cfg_wr) begin
            unique case (epm_pkg::t_reg_idx'(paddr[2]))
                epm_pkg::REG_ENC_SCALE:  r_enc_scale  <= pwdata;
                epm_pkg::REG_STEP_SCALE: r_step_scale <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (epm_pkg::t_reg_idx'(paddr[2]))
            epm_pkg::REG_ENC_SCALE:  prdata = r_enc_scale;
            epm_pkg::REG_STEP_SCALE: prdata = r_step_scale;
            default:                 prdata = '0;
        endcase
    end

    assign scaled = (|r_enc_scale) & (|r_step_scale);

    // ---------------- tracking state ----------------
    assign o_s_tready = (r_state == ST_IDLE);
    assign s_accept   = i_s_tvalid & o_s_tready;
    assign raw        = i_s_tdata[RW-1:0];
    assign fwd        = raw - r_prev_raw;

    always_comb begin
        n_pos      = r_pos;
        n_prev_raw = r_prev_raw;
        n_dir      = r_dir;
        n_steps    = r_steps;
        n_idx_pos  = r_idx_pos;
        n_idx_cnt  = r_idx_cnt;
        unique case (epm_pkg::t_mode'(i_s_tuser))
            epm_pkg::MODE_SAMPLE, epm_pkg::MODE_INDEX: begin
                n_prev_raw = raw;
                if (fwd != '0) begin
                    if (fwd <= epm_pkg::HALF_SPAN) begin
                        n_pos = r_pos + {{(W-RW){1'b0}}, fwd};
                        n_dir = epm_pkg::DIR_FWD;
                    end else begin
                        // a large forward step is a backward wrap
                        n_pos = r_pos + {{(W-RW){1'b1}}, fwd};
                        n_dir = epm_pkg::DIR_REV;
                    end
                end
                if (epm_pkg::t_mode'(i_s_tuser) == epm_pkg::MODE_INDEX) begin
                    n_idx_pos = n_pos;
                    n_idx_cnt = r_idx_cnt + 1'b1;
                end
            end
            epm_pkg::MODE_STEP: begin
                n_steps = i_s_tdata[RW] ? (r_steps + 1'b1) : (r_steps - 1'b1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_prev_raw <= '0;
            r_dir      <= epm_pkg::DIR_NONE;
            r_steps    <= '0;
            r_idx_pos  <= '0;
            r_idx_cnt  <= '0;
        end else if (s_accept) begin
            r_pos      <= n_pos;
            r_prev_raw <= n_prev_raw;
            r_dir      <= n_dir;
            r_steps    <= n_steps;
            r_idx_pos  <= n_idx_pos;
            r_idx_cnt  <= n_idx_cnt;
        end
    end

    // ---------------- expected count ----------------
    assign mag = n_steps[W-1] ? (W'(0) - n_steps) : n_steps;

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_neg <= n_steps[W-1];
        end
    end

    epm_mul #(
        .DIGIT_BITS (DIGIT_BITS)
    ) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (s_accept & scaled),
        .i_mcand   (mag),
        .i_mplier  (r_enc_scale),
        .o_done    (mul_done),
        .o_product (product)
    );

    assign div_start = (r_state == ST_MUL) & mul_done;

    epm_div #(
        .DIGIT_BITS (DIGIT_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (product),
        .i_divisor  (r_step_scale),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    // saturate the magnitude to 2^31 - 1 forward or 2^31 backward
    always_comb begin
        if (r_neg) begin
            sat  = (|quot[2*W-1:W]) | (quot[W-1] & (|quot[W-2:0]));
            qmag = sat ? {1'b1, {(W-1){1'b0}}} : quot[W-1:0];
        end else begin
            sat  = |quot[2*W-1:W-1];
            qmag = sat ? {1'b0, {(W-1){1'b1}}} : quot[W-1:0];
        end
        if (!scaled) begin
            expect_cnt = '0;
            pos_err    = '0;
        end else begin
            expect_cnt = r_neg ? (W'(0) - qmag) : qmag;
            pos_err    = r_pos - expect_cnt;
        end
    end

    // ---------------- sequencer ----------------
    assign out_free = ~r_m_valid | i_m_tready;
    assign load     = (r_state == ST_LOAD) & out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (s_accept) n_state = scaled ? ST_MUL : ST_LOAD;
            ST_MUL:  if (mul_done) n_state = ST_DIV;
            ST_DIV:  if (div_done) n_state = ST_LOAD;
            ST_LOAD: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_m_data <= {{OUT_PAD{1'b0}}, pos_err, expect_cnt, r_dir, r_prev_raw,
                         r_idx_cnt, r_idx_pos, r_steps, r_pos};
            r_m_user <= scaled;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

    // ---------------- assertions ----------------
    `ASSERT_NEXT(a_scaled_item_multiplies, i_clk, i_rst_n,
                 s_accept && scaled, r_state == ST_MUL,
                 "scaled item did not start the multiplier")
    `ASSERT_NEXT(a_load_holds_on_stall, i_clk, i_rst_n,
                 (r_state == ST_LOAD) && r_m_valid && !i_m_tready, r_state == ST_LOAD,
                 "result dropped while output stalled")
    `ASSERT_IMPL(a_valid_from_load, i_clk, i_rst_n,
                 $rose(r_m_valid), $past(r_state) == ST_LOAD,
                 "result appeared outside the load state")
    `ASSERT_IMPL(a_unscaled_zero, i_clk, i_rst_n,
                 r_m_valid && !r_m_user, r_m_data[209:146] == '0,
                 "unscaled result carries nonzero expected count or error")

endmodule
